// ===== design/bmc_pkg.sv =====
package bmc_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;

  localparam int ColW    = $clog2(MaxWidth);
  localparam int RowW    = $clog2(MaxHeight);
  localparam int WidthW  = 12;
  localparam int HeightW = 13;
  localparam int IdxW    = $clog2(MaxWidth * MaxHeight) + 1;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 13;

  localparam logic [CfgIndexW-1:0] RegFrameWidth  = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] RegFrameHeight = CfgIndexW'(1);

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

  localparam logic [IdxW-1:0] TotalReset    = IdxW'(int'(WidthReset) * int'(HeightReset));
  localparam logic [IdxW-1:0] RowStartReset =
    IdxW'(int'(WidthReset) * (int'(HeightReset) - 1));

  localparam int FlagW = 2;
  localparam int LineW = 2 * FlagW;
  localparam int WinW  = 9 * FlagW;

  localparam int FlagWhite = 0;
  localparam int FlagBlack = 1;

  localparam int CenterWhite = 4 * FlagW + FlagWhite;
  localparam int RowEndWhite = 7 * FlagW + FlagWhite;

  localparam logic [WinW-1:0] NeighborBlack = WinW'(18'h2A8AA);

  localparam logic [7:0] PixWhite = 8'd255;
  localparam logic [7:0] PixBlack = 8'd0;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    logic             valid;
    logic             pixel;
    logic             has_out;
    logic             end_of_row;
    logic             border;
    logic             sel_upper;
    logic             last;
    logic [FlagW-1:0] flag;
    logic [ColW-1:0]  addr;
  } stage_t;

endpackage

// ===== design/bmc_ram.sv =====
module bmc_ram #(
  parameter int DataWidth = 4,
  parameter int Depth     = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [DataWidth-1:0]     wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [DataWidth-1:0]     rd_data
);

  logic [DataWidth-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/bmc_front.sv =====
module bmc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  input  logic [0:0]                     s_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmc_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [bmc_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           b_go,
  output bmc_pkg::stage_t                stage,
  output logic                           rd_fire,
  output logic [bmc_pkg::ColW-1:0]       rd_addr,
  output logic                           clearing,
  output logic [bmc_pkg::ColW-1:0]       clr_addr
);

  logic [bmc_pkg::WidthW-1:0]  width;
  logic [bmc_pkg::HeightW-1:0] height;
  logic [bmc_pkg::WidthW-1:0]  width_in;
  logic [bmc_pkg::HeightW-1:0] height_in;
  logic [bmc_pkg::WidthW-1:0]  mul_w;
  logic [bmc_pkg::HeightW-1:0] mul_h;
  logic [bmc_pkg::IdxW-1:0]    total, total_next;
  logic [bmc_pkg::IdxW-1:0]    row_start, row_start_next;

  logic [bmc_pkg::ColW-1:0] col, col_next;
  logic [bmc_pkg::RowW-1:0] row, row_next;
  logic                     draining, draining_next;
  logic [bmc_pkg::IdxW-1:0] out_idx, out_idx_next;
  logic [bmc_pkg::IdxW-1:0] out_idx_inc;
  logic [bmc_pkg::IdxW-1:0] drain_off;
  logic [bmc_pkg::ColW-1:0] width_last;
  bmc_pkg::stage_t          stage_next;
  logic [bmc_pkg::FlagW-1:0] pix_flag;

  assign cfg_ready = 1'b1;
  assign s_tready  = !clearing && (!stage.valid || b_go);
  assign rd_fire   = s_tvalid && s_tready;

  assign width_last  = bmc_pkg::ColW'(width - bmc_pkg::WidthW'(1));
  assign out_idx_inc = out_idx + bmc_pkg::IdxW'(1);
  assign drain_off   = out_idx - row_start;

  always_comb begin
    width_in  = cfg_data[bmc_pkg::WidthW-1:0];
    height_in = cfg_data[bmc_pkg::HeightW-1:0];
    if (width_in == '0) begin
      width_in = bmc_pkg::WidthW'(1);
    end else if (width_in > bmc_pkg::WidthW'(bmc_pkg::MaxWidth)) begin
      width_in = bmc_pkg::WidthW'(bmc_pkg::MaxWidth);
    end
    if (height_in == '0) begin
      height_in = bmc_pkg::HeightW'(1);
    end else if (height_in > bmc_pkg::HeightW'(bmc_pkg::MaxHeight)) begin
      height_in = bmc_pkg::HeightW'(bmc_pkg::MaxHeight);
    end
  end

  always_comb begin
    mul_w = width;
    mul_h = height;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == bmc_pkg::RegFrameWidth) begin
        mul_w = width_in;
      end else if (cfg_index == bmc_pkg::RegFrameHeight) begin
        mul_h = height_in;
      end
    end
    total_next     = bmc_pkg::IdxW'(mul_w) * bmc_pkg::IdxW'(mul_h);
    row_start_next = total_next - bmc_pkg::IdxW'(mul_w);
  end

  always_comb begin
    pix_flag = '0;
    if (s_tdata == bmc_pkg::PixWhite) begin
      pix_flag[bmc_pkg::FlagWhite] = 1'b1;
    end else if (s_tdata == bmc_pkg::PixBlack) begin
      pix_flag[bmc_pkg::FlagBlack] = 1'b1;
    end
  end

  always_comb begin
    stage_next    = stage;
    col_next      = col;
    row_next      = row;
    draining_next = draining;
    out_idx_next  = out_idx;
    rd_addr       = stage.addr;
    if (b_go) begin
      stage_next.valid = 1'b0;
    end
    if (rd_fire) begin
      stage_next       = '0;
      stage_next.valid = 1'b1;
      if (s_tuser == bmc_pkg::OP_FLUSH) begin
        if (draining && (out_idx < total)) begin
          stage_next.has_out = 1'b1;
          if (out_idx >= row_start) begin
            stage_next.addr = drain_off[bmc_pkg::ColW-1:0];
          end else begin
            stage_next.addr      = width_last;
            stage_next.sel_upper = 1'b1;
          end
          stage_next.last = (out_idx_inc >= total);
          out_idx_next    = out_idx_inc;
          if (out_idx_inc >= total) begin
            draining_next = 1'b0;
          end
        end else begin
          draining_next = 1'b0;
        end
      end else begin
        draining_next         = 1'b0;
        stage_next.pixel      = 1'b1;
        stage_next.flag       = pix_flag;
        stage_next.addr       = col;
        stage_next.end_of_row = (col == '0) && (row >= bmc_pkg::RowW'(2));
        stage_next.has_out    = stage_next.end_of_row || ((col != '0) && (row != '0));
        stage_next.border     = (row == bmc_pkg::RowW'(1)) ||
                                ({1'b0, row} == height) ||
                                (col == bmc_pkg::ColW'(1)) ||
                                ({1'b0, col} == width);
        if (({1'b0, col} + bmc_pkg::WidthW'(1)) >= width) begin
          col_next = '0;
          if (({1'b0, row} + bmc_pkg::HeightW'(1)) >= height) begin
            row_next      = '0;
            draining_next = 1'b1;
            out_idx_next  = (height >= bmc_pkg::HeightW'(2)) ?
                            row_start - bmc_pkg::IdxW'(1) : '0;
          end else begin
            row_next = row + bmc_pkg::RowW'(1);
          end
        end else begin
          col_next = col + bmc_pkg::ColW'(1);
        end
      end
      rd_addr = stage_next.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= bmc_pkg::WidthReset;
      height    <= bmc_pkg::HeightReset;
      total     <= bmc_pkg::TotalReset;
      row_start <= bmc_pkg::RowStartReset;
      col       <= '0;
      row       <= '0;
      draining  <= 1'b0;
      out_idx   <= '0;
      stage     <= '0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
    end else begin
      width     <= mul_w;
      height    <= mul_h;
      total     <= total_next;
      row_start <= row_start_next;
      col       <= col_next;
      row       <= row_next;
      draining  <= draining_next;
      out_idx   <= out_idx_next;
      stage     <= stage_next;
      if (clearing) begin
        clr_addr <= clr_addr + bmc_pkg::ColW'(1);
        if (clr_addr == bmc_pkg::ColW'(bmc_pkg::MaxWidth - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/bmc_back.sv =====
module bmc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  bmc_pkg::stage_t            stage,
  input  logic                       rd_fire,
  input  logic [bmc_pkg::ColW-1:0]   rd_addr,
  input  logic [bmc_pkg::LineW-1:0]  rd_data,
  output logic                       b_go,
  output logic                       wr_en,
  output logic [bmc_pkg::ColW-1:0]   wr_addr,
  output logic [bmc_pkg::LineW-1:0]  wr_data,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,
  output logic                       m_tlast
);

  logic [bmc_pkg::WinW-1:0]  window;
  logic [bmc_pkg::WinW-1:0]  win_shift;
  logic                      fwd;
  logic [bmc_pkg::LineW-1:0] fwd_data;
  logic [bmc_pkg::LineW-1:0] line;
  logic [bmc_pkg::FlagW-1:0] upper;
  logic [bmc_pkg::FlagW-1:0] middle;
  logic                      hit;
  logic                      contour;

  assign line      = fwd ? fwd_data : rd_data;
  assign upper     = line[bmc_pkg::FlagW-1:0];
  assign middle    = line[bmc_pkg::LineW-1:bmc_pkg::FlagW];
  assign win_shift = {stage.flag, middle, upper,
                      window[bmc_pkg::WinW-1:3*bmc_pkg::FlagW]};

  assign b_go    = stage.valid && (!stage.has_out || !m_tvalid || m_tready);
  assign wr_en   = b_go && stage.pixel;
  assign wr_addr = stage.addr;
  assign wr_data = {stage.flag, middle};
  assign m_tdata = contour ? bmc_pkg::PixWhite : bmc_pkg::PixBlack;

  always_comb begin
    priority if (!stage.pixel) begin
      hit = stage.sel_upper ? upper[bmc_pkg::FlagWhite] : middle[bmc_pkg::FlagWhite];
    end else if (stage.end_of_row) begin
      hit = window[bmc_pkg::RowEndWhite];
    end else begin
      hit = win_shift[bmc_pkg::CenterWhite] &&
            (stage.border || |(win_shift & bmc_pkg::NeighborBlack));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      window   <= '0;
      fwd      <= 1'b0;
    end else begin
      if (b_go && stage.has_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (wr_en) begin
        window <= win_shift;
      end
      fwd <= rd_fire && wr_en && (rd_addr == stage.addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr_data;
    if (b_go && stage.has_out) begin
      contour <= hit;
      m_tlast <= stage.last;
    end
  end

endmodule

// ===== design/binary_mask_contour_3x3.sv =====
// Pipeline: a word enters the stage register, its result the output register; a pixel's
// result is released by the pixel one row plus one column later, or by a flush word.
// Throughput: one word per cycle unless the output stalls, limited by the line store's
// single read and write port. Reset: synchronous; registers go to 640 x 480, then a
// sweep zeroes the line store while s_tready is low (configuration writes still taken).
module binary_mask_contour_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // pixel
  input  logic [0:0]                    s_tuser,   // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // edge_value
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [bmc_pkg::CfgDataW-1:0]  cfg_data
);

  bmc_pkg::stage_t           stage;
  logic                      b_go;
  logic                      rd_fire;
  logic [bmc_pkg::ColW-1:0]  rd_addr;
  logic [bmc_pkg::LineW-1:0] rd_data;
  logic                      clearing;
  logic [bmc_pkg::ColW-1:0]  clr_addr;
  logic                      b_wr_en;
  logic [bmc_pkg::ColW-1:0]  b_wr_addr;
  logic [bmc_pkg::LineW-1:0] b_wr_data;
  logic                      wr_en;
  logic [bmc_pkg::ColW-1:0]  wr_addr;
  logic [bmc_pkg::LineW-1:0] wr_data;

  assign wr_en   = clearing || b_wr_en;
  assign wr_addr = clearing ? clr_addr : b_wr_addr;
  assign wr_data = clearing ? '0 : b_wr_data;

  bmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .b_go      (b_go),
    .stage     (stage),
    .rd_fire   (rd_fire),
    .rd_addr   (rd_addr),
    .clearing  (clearing),
    .clr_addr  (clr_addr)
  );

  bmc_ram #(
    .DataWidth (bmc_pkg::LineW),
    .Depth     (bmc_pkg::MaxWidth)
  ) u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .rd_fire  (rd_fire),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .b_go     (b_go),
    .wr_en    (b_wr_en),
    .wr_addr  (b_wr_addr),
    .wr_data  (b_wr_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== design/bmc_checker.sv =====
module bmc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input taken during line store sweep");

  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output word without an input word two cycles earlier");

  a_out_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == bmc_pkg::PixWhite) || (m_tdata == bmc_pkg::PixBlack))
    else $error("output value is neither 0 nor 255");

endmodule

bind binary_mask_contour_3x3 bmc_checker u_checker (.*);
